FILE: rtl/nke_pkg.sv
// ----------------------------------------------------------------------------
// nke_pkg
// Shared types, constants and helpers of the normalized keypoint error loss.
// ----------------------------------------------------------------------------
package nke_pkg;

  localparam int MAX_POINTS = 65536;
  localparam int FRAC_BITS  = 16;

  localparam int COUNT_W   = 17;
  localparam int SUM_W     = 56;
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 33;
  localparam int NORM_W    = 31;
  localparam int LOSS_W    = 31;

  localparam int MUL_A_W   = 52;
  localparam int MUL_B_W   = 34;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int RAD_W     = 66;
  localparam int ROOT_W    = 34;
  localparam int DIV_W     = 82;

  localparam logic [COUNT_W-1:0] COUNT_CAP =
    (MAX_POINTS < 131071) ? COUNT_W'(MAX_POINTS) : COUNT_W'(131071);
  localparam logic signed [COORD_W-1:0] HALF_ONE = COORD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};

  localparam logic KIND_LOSS = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] pred_x;
    logic signed [COORD_W-1:0] pred_y;
    logic signed [COORD_W-1:0] true_x;
    logic signed [COORD_W-1:0] true_y;
    logic signed [COORD_W-1:0] vis_score;
    logic [NORM_W-1:0]         norm_scale;
    logic signed [COORD_W-1:0] loss_grad;
    logic                      last_item;
  } req_t;

  typedef struct packed {
    logic                      result_kind;
    logic [LOSS_W-1:0]         mean_loss;
    logic signed [COORD_W-1:0] grad_x;
    logic signed [COORD_W-1:0] grad_y;
    logic                      none_visible;
  } rsp_t;

  typedef struct packed {
    logic               backward;
    logic               visible;
    logic               last;
    logic [DIFF_W-1:0]  adx;
    logic [DIFF_W-1:0]  ady;
    logic               sx;
    logic               sy;
    logic [COORD_W-1:0] mag_g;
    logic               sg;
    logic [NORM_W-1:0]  norm;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_ND,
    ST_ACC,
    ST_MEAN,
    ST_DC,
    ST_DCN,
    ST_NX,
    ST_GX,
    ST_NY,
    ST_GY,
    ST_EMIT
  } state_t;

  function automatic logic [COORD_W-1:0] grad_sat(input logic [DIV_W-1:0] q,
                                                  input logic neg);
    logic [COORD_W-1:0] r;
    r = '0;
    if (q != '0) begin
      if (neg) begin
        if ((|q[DIV_W-1:COORD_W]) || (q[COORD_W-1] && (|q[COORD_W-2:0]))) begin
          r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
          r = COORD_W'(-q[COORD_W-1:0]);
        end
      end else begin
        if (|q[DIV_W-1:COORD_W-1]) begin
          r = {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
          r = q[COORD_W-1:0];
        end
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/nke_front.sv
// ----------------------------------------------------------------------------
// nke_front
// Classifies an incoming keypoint: differences, magnitudes, signs, visibility.
// ----------------------------------------------------------------------------
module nke_front (
  input  nke_pkg::req_t req,
  output nke_pkg::cmd_t cmd
);

  logic signed [nke_pkg::DIFF_W-1:0] dx;
  logic signed [nke_pkg::DIFF_W-1:0] dy;
  logic signed [nke_pkg::DIFF_W-1:0] g;

  always_comb begin
    dx = {req.pred_x[31], req.pred_x} - {req.true_x[31], req.true_x};
    dy = {req.pred_y[31], req.pred_y} - {req.true_y[31], req.true_y};
    g  = {req.loss_grad[31], req.loss_grad};
    cmd.backward = req.req_type;
    cmd.visible  = req.vis_score > nke_pkg::HALF_ONE;
    cmd.last     = req.last_item;
    cmd.sx       = dx[nke_pkg::DIFF_W-1];
    cmd.sy       = dy[nke_pkg::DIFF_W-1];
    cmd.sg       = g[nke_pkg::DIFF_W-1];
    cmd.adx      = dx[nke_pkg::DIFF_W-1] ? nke_pkg::DIFF_W'(-dx) : nke_pkg::DIFF_W'(dx);
    cmd.ady      = dy[nke_pkg::DIFF_W-1] ? nke_pkg::DIFF_W'(-dy) : nke_pkg::DIFF_W'(dy);
    cmd.mag_g    = g[nke_pkg::DIFF_W-1] ? nke_pkg::COORD_W'(-g) : nke_pkg::COORD_W'(g);
    cmd.norm     = (req.norm_scale == '0) ? nke_pkg::NORM_W'(1) : req.norm_scale;
  end

endmodule

FILE: rtl/nke_queue.sv
// ----------------------------------------------------------------------------
// nke_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module nke_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  nke_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output nke_pkg::cmd_t rd_data,
  output logic          empty
);

  nke_pkg::cmd_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_wr;
  logic          do_rd;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_data = mem[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/nke_mul.sv
// ----------------------------------------------------------------------------
// nke_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module nke_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [nke_pkg::MUL_A_W-1:0]  a,
  input  logic [nke_pkg::MUL_B_W-1:0]  b,
  output logic [nke_pkg::MUL_P_W-1:0]  prod,
  output logic                         done
);

  logic [nke_pkg::MUL_P_W-1:0] a_sh;
  logic [nke_pkg::MUL_B_W-1:0] b_sh;
  logic [5:0]                  cnt;
  logic                        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(nke_pkg::MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= nke_pkg::MUL_P_W'(a);
      b_sh <= b;
      prod <= '0;
    end else if (busy) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

FILE: rtl/nke_sqrt.sv
// ----------------------------------------------------------------------------
// nke_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module nke_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [nke_pkg::RAD_W-1:0]    rad_in,
  output logic [nke_pkg::ROOT_W-1:0]   root,
  output logic                         done
);

  localparam int SHW = 2 * nke_pkg::ROOT_W;
  localparam int REMW = nke_pkg::ROOT_W + 4;

  logic [SHW-1:0]  rad;
  logic [REMW-1:0] rem;
  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic [5:0]      cnt;
  logic            busy;

  assign rem_sh = {rem[REMW-3:0], rad[SHW-1:SHW-2]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(nke_pkg::ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= SHW'(rad_in);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= rad << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[nke_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[nke_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/nke_div.sv
// ----------------------------------------------------------------------------
// nke_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nke_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [nke_pkg::DIV_W-1:0]  num,
  input  logic [nke_pkg::DIV_W-1:0]  den,
  output logic [nke_pkg::DIV_W-1:0]  quo,
  output logic                       done
);

  logic [nke_pkg::DIV_W:0]   rem;
  logic [nke_pkg::DIV_W:0]   trial;
  logic [nke_pkg::DIV_W:0]   den_x;
  logic [6:0]                cnt;
  logic                      busy;

  assign trial = {rem[nke_pkg::DIV_W-1:0], quo[nke_pkg::DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'(nke_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      den_x <= {1'b0, den};
      rem   <= '0;
    end else if (busy) begin
      if (trial >= den_x) begin
        rem <= trial - den_x;
        quo <= {quo[nke_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[nke_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/nke_back.sv
// ----------------------------------------------------------------------------
// nke_back
// Sequencer that runs each command through the shared arithmetic units.
// ----------------------------------------------------------------------------
module nke_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  nke_pkg::cmd_t q_data,
  output logic          q_pop,
  output nke_pkg::rsp_t rsp,
  output logic          empty,
  input  logic          pop
);

  nke_pkg::state_t state;
  nke_pkg::state_t state_next;
  nke_pkg::cmd_t   cmd;

  logic [nke_pkg::SUM_W-1:0]   error_sum;
  logic [nke_pkg::COUNT_W-1:0] running_count;
  logic [nke_pkg::COUNT_W-1:0] held_count;
  logic [nke_pkg::RAD_W-1:0]   sqx;
  logic [nke_pkg::ROOT_W-1:0]  root_len;
  logic [nke_pkg::DIV_W-1:0]   den;
  logic [nke_pkg::LOSS_W-1:0]  loss_val;
  logic [nke_pkg::COORD_W-1:0] gx;
  logic [nke_pkg::COORD_W-1:0] gy;
  logic                        rsp_valid;
  logic                        launched;

  logic                        mul_start;
  logic [nke_pkg::MUL_A_W-1:0] mul_a;
  logic [nke_pkg::MUL_B_W-1:0] mul_b;
  logic [nke_pkg::MUL_P_W-1:0] mul_p;
  logic                        mul_done;
  logic                        sqrt_start;
  logic [nke_pkg::ROOT_W-1:0]  sqrt_root;
  logic                        sqrt_done;
  logic                        div_start;
  logic [nke_pkg::DIV_W-1:0]   div_n;
  logic [nke_pkg::DIV_W-1:0]   div_d;
  logic [nke_pkg::DIV_W-1:0]   div_q;
  logic                        div_done;
  logic                        unit_done;
  logic                        slot_free;
  logic [nke_pkg::SUM_W:0]     sum_wide;

  assign slot_free = !rsp_valid || pop;
  assign empty     = !rsp_valid;
  assign unit_done = mul_done || sqrt_done || div_done;
  assign sum_wide  = {1'b0, error_sum} + (nke_pkg::SUM_W + 1)'(div_q[nke_pkg::SUM_W-1:0]);

  nke_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_p),
    .done  (mul_done)
  );

  nke_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (sqrt_start),
    .rad_in (sqx + mul_p[nke_pkg::RAD_W-1:0]),
    .root   (sqrt_root),
    .done   (sqrt_done)
  );

  nke_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_n),
    .den   (div_d),
    .quo   (div_q),
    .done  (div_done)
  );

  always_comb begin
    state_next = state;
    case (state)
      nke_pkg::ST_IDLE: begin
        if (!q_empty) begin
          if (q_data.backward) begin
            state_next = (q_data.visible && held_count != '0) ? nke_pkg::ST_SQX
                                                               : nke_pkg::ST_EMIT;
          end else if (q_data.visible) begin
            state_next = nke_pkg::ST_SQX;
          end else if (q_data.last) begin
            state_next = (running_count != '0) ? nke_pkg::ST_MEAN : nke_pkg::ST_EMIT;
          end
        end
      end
      nke_pkg::ST_SQX:  if (mul_done) state_next = nke_pkg::ST_SQY;
      nke_pkg::ST_SQY:  if (mul_done) state_next = nke_pkg::ST_ROOT;
      nke_pkg::ST_ROOT: begin
        if (sqrt_done) begin
          if (!cmd.backward) begin
            state_next = nke_pkg::ST_ND;
          end else begin
            state_next = (sqrt_root == '0) ? nke_pkg::ST_EMIT : nke_pkg::ST_DC;
          end
        end
      end
      nke_pkg::ST_ND:   if (div_done) state_next = nke_pkg::ST_ACC;
      nke_pkg::ST_ACC:  state_next = cmd.last ? nke_pkg::ST_MEAN : nke_pkg::ST_IDLE;
      nke_pkg::ST_MEAN: if (div_done) state_next = nke_pkg::ST_EMIT;
      nke_pkg::ST_DC:   if (mul_done) state_next = nke_pkg::ST_DCN;
      nke_pkg::ST_DCN:  if (mul_done) state_next = nke_pkg::ST_NX;
      nke_pkg::ST_NX:   if (mul_done) state_next = nke_pkg::ST_GX;
      nke_pkg::ST_GX:   if (div_done) state_next = nke_pkg::ST_NY;
      nke_pkg::ST_NY:   if (mul_done) state_next = nke_pkg::ST_GY;
      nke_pkg::ST_GY:   if (div_done) state_next = nke_pkg::ST_EMIT;
      nke_pkg::ST_EMIT: if (slot_free) state_next = nke_pkg::ST_IDLE;
      default:          state_next = nke_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_n      = '0;
    div_d      = '0;
    case (state)
      nke_pkg::ST_IDLE: q_pop = !q_empty;
      nke_pkg::ST_SQX: begin
        mul_start = !launched;
        mul_a     = nke_pkg::MUL_A_W'(cmd.adx);
        mul_b     = nke_pkg::MUL_B_W'(cmd.adx);
      end
      nke_pkg::ST_SQY: begin
        mul_start = !launched;
        mul_a     = nke_pkg::MUL_A_W'(cmd.ady);
        mul_b     = nke_pkg::MUL_B_W'(cmd.ady);
      end
      nke_pkg::ST_ROOT: sqrt_start = !launched;
      nke_pkg::ST_ND: begin
        div_start = !launched;
        div_n     = nke_pkg::DIV_W'(root_len) << nke_pkg::FRAC_BITS;
        div_d     = nke_pkg::DIV_W'(cmd.norm);
      end
      nke_pkg::ST_MEAN: begin
        div_start = !launched;
        div_n     = nke_pkg::DIV_W'(error_sum);
        div_d     = nke_pkg::DIV_W'(running_count);
      end
      nke_pkg::ST_DC: begin
        mul_start = !launched;
        mul_a     = nke_pkg::MUL_A_W'(root_len);
        mul_b     = nke_pkg::MUL_B_W'(held_count);
      end
      nke_pkg::ST_DCN: begin
        mul_start = !launched;
        mul_a     = mul_p[nke_pkg::MUL_A_W-1:0];
        mul_b     = nke_pkg::MUL_B_W'(cmd.norm);
      end
      nke_pkg::ST_NX: begin
        mul_start = !launched;
        mul_a     = nke_pkg::MUL_A_W'(cmd.adx);
        mul_b     = nke_pkg::MUL_B_W'(cmd.mag_g);
      end
      nke_pkg::ST_NY: begin
        mul_start = !launched;
        mul_a     = nke_pkg::MUL_A_W'(cmd.ady);
        mul_b     = nke_pkg::MUL_B_W'(cmd.mag_g);
      end
      nke_pkg::ST_GX, nke_pkg::ST_GY: begin
        div_start = !launched;
        div_n     = nke_pkg::DIV_W'(mul_p[63:0]) << nke_pkg::FRAC_BITS;
        div_d     = den;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= nke_pkg::ST_IDLE;
      launched      <= 1'b0;
      error_sum     <= '0;
      running_count <= '0;
      held_count    <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (unit_done) begin
        launched <= 1'b0;
      end else if (mul_start || sqrt_start || div_start) begin
        launched <= 1'b1;
      end
      if (state == nke_pkg::ST_ACC) begin
        error_sum <= sum_wide[nke_pkg::SUM_W] ? nke_pkg::SUM_MAX
                                              : sum_wide[nke_pkg::SUM_W-1:0];
        if (running_count < nke_pkg::COUNT_CAP) begin
          running_count <= running_count + nke_pkg::COUNT_W'(1);
        end
      end
      if (pop && rsp_valid) begin
        rsp_valid <= 1'b0;
      end
      if (state == nke_pkg::ST_EMIT && slot_free) begin
        rsp_valid <= 1'b1;
        if (!cmd.backward) begin
          held_count    <= running_count;
          running_count <= '0;
          error_sum     <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == nke_pkg::ST_IDLE && !q_empty) begin
      cmd      <= q_data;
      loss_val <= '0;
      gx       <= '0;
      gy       <= '0;
    end
    if (state == nke_pkg::ST_SQX && mul_done) begin
      sqx <= mul_p[nke_pkg::RAD_W-1:0];
    end
    if (state == nke_pkg::ST_ROOT && sqrt_done) begin
      root_len <= sqrt_root;
    end
    if (state == nke_pkg::ST_DCN && mul_done) begin
      den <= mul_p[nke_pkg::DIV_W-1:0];
    end
    if (state == nke_pkg::ST_MEAN && div_done) begin
      loss_val <= (|div_q[nke_pkg::DIV_W-1:nke_pkg::LOSS_W]) ? nke_pkg::LOSS_MAX
                                                             : div_q[nke_pkg::LOSS_W-1:0];
    end
    if (state == nke_pkg::ST_GX && div_done) begin
      gx <= nke_pkg::grad_sat(div_q, cmd.sx ^ cmd.sg);
    end
    if (state == nke_pkg::ST_GY && div_done) begin
      gy <= nke_pkg::grad_sat(div_q, cmd.sy ^ cmd.sg);
    end
    if (state == nke_pkg::ST_EMIT && slot_free) begin
      rsp.result_kind  <= cmd.backward ? nke_pkg::KIND_GRAD : nke_pkg::KIND_LOSS;
      rsp.mean_loss    <= cmd.backward ? '0 : loss_val;
      rsp.grad_x       <= cmd.backward ? gx : '0;
      rsp.grad_y       <= cmd.backward ? gy : '0;
      rsp.none_visible <= cmd.backward ? (held_count == '0) : (running_count == '0);
    end
  end

endmodule

FILE: rtl/normalized_keypoint_error_loss_unit.sv
// ----------------------------------------------------------------------------
// normalized_keypoint_error_loss_unit
// Normalized mean error keypoint loss and its gradient, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One keypoint per pushed item. A two-entry command queue holds classified
// items while a sequencer works through one at a time with a shared
// bit-serial multiplier, square root and divider. An invisible forward
// keypoint uses no unit but the mean division when it is last; a visible
// forward keypoint takes two products, one root and one division, plus the
// mean division on the last one; a visible backward keypoint takes six
// products, one root and two divisions. One finished result is held in an
// output register until popped; the queue keeps taking items meanwhile.
module normalized_keypoint_error_loss_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nke_pkg::req_t req,
  output logic          full,
  output logic          empty,
  input  logic          pop,
  output nke_pkg::rsp_t rsp
);

  nke_pkg::cmd_t front_cmd;
  nke_pkg::cmd_t q_data;
  logic          q_empty;
  logic          q_pop;

  nke_front u_front (
    .req (req),
    .cmd (front_cmd)
  );

  nke_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  nke_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .rsp     (rsp),
    .empty   (empty),
    .pop     (pop)
  );

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !q_empty)
    else $error("transfer into queue lost");

  a_loss_no_grad: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.result_kind == nke_pkg::KIND_LOSS) |-> (rsp.grad_x == '0 && rsp.grad_y == '0))
    else $error("loss result carries gradient");

  a_grad_no_loss: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.result_kind == nke_pkg::KIND_GRAD) |-> (rsp.mean_loss == '0))
    else $error("gradient result carries loss");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.none_visible) |-> (rsp.mean_loss == '0 && rsp.grad_x == '0 && rsp.grad_y == '0))
    else $error("nonzero result with no visible points");

endmodule
